### rtl/door_auto_close_controller_assert.svh
// Assertion macros for the door auto-close controller.
`ifndef DOOR_AUTO_CLOSE_CONTROLLER_ASSERT_SVH
`define DOOR_AUTO_CLOSE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define DACC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define DACC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dacc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dacc_pkg;

  // Sensor position codes
  localparam logic [1:0] POS_NONE    = 2'd0;
  localparam logic [1:0] POS_OUTSIDE = 2'd1;
  localparam logic [1:0] POS_INSIDE  = 2'd2;
  localparam logic [1:0] POS_BOTH    = 2'd3;

  // Door motor states
  localparam logic [1:0] DOOR_CLOSED  = 2'd0;
  localparam logic [1:0] DOOR_OPENING = 2'd1;
  localparam logic [1:0] DOOR_OPEN    = 2'd2;
  localparam logic [1:0] DOOR_CLOSING = 2'd3;

  // Door commands
  localparam logic [1:0] MOTOR_IDLE  = 2'd0;
  localparam logic [1:0] MOTOR_OPEN  = 2'd1;
  localparam logic [1:0] MOTOR_CLOSE = 2'd2;

  // Close timer modes
  localparam logic [1:0] MODE_NONE        = 2'd0;
  localparam logic [1:0] MODE_NO_ENTRY    = 2'd1;
  localparam logic [1:0] MODE_AFTER_ENTRY = 2'd2;

  // Door transition event codes
  localparam logic [3:0] EV_NONE           = 4'd0;
  localparam logic [3:0] EV_MANUAL_OPENING = 4'd1;
  localparam logic [3:0] EV_ENTRY          = 4'd2;
  localparam logic [3:0] EV_EXIT           = 4'd3;
  localparam logic [3:0] EV_UNKNOWN_OPEN   = 4'd4;
  localparam logic [3:0] EV_MANUAL_CLOSING = 4'd5;
  localparam logic [3:0] EV_CLOSING        = 4'd6;
  localparam logic [3:0] EV_OPENED         = 4'd7;
  localparam logic [3:0] EV_CLOSED         = 4'd8;

  // Configuration register indexes
  localparam logic [1:0] CFG_CLOSE_DELAY_NO_ENTRY    = 2'd0;
  localparam logic [1:0] CFG_CLOSE_DELAY_AFTER_ENTRY = 2'd1;
  localparam logic [1:0] CFG_CLOSE_SETTLE            = 2'd2;
  localparam logic [1:0] CFG_EXIT_CONFIRM            = 2'd3;

  // Configuration reset values
  localparam logic [15:0] CLOSE_DELAY_NO_ENTRY_RST    = 16'd15000;
  localparam logic [15:0] CLOSE_DELAY_AFTER_ENTRY_RST = 16'd2000;
  localparam logic [15:0] CLOSE_SETTLE_RST            = 16'd800;
  localparam logic [15:0] EXIT_CONFIRM_RST            = 16'd2000;

  typedef struct packed {
    logic [1:0]  car_position;
    logic [1:0]  door_state;
    logic        last_move_manual;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] door_command;
    logic       car_parked;
    logic       parked_event;
    logic       left_event;
    logic [3:0] transition_event;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/door_auto_close_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Garage door auto-close controller. Each tick transaction (sensor position, door state,
// manual flag, millisecond time) yields exactly one result transaction (door command,
// car-present belief, parked/left events, door transition code). A tick can be accepted
// every clock cycle while in_ready is high. An accepted tick sits in the input register,
// and the edge on which the result register advances moves it through the single-pass
// decision logic into the result register and updates the controller state, so its
// result is taken from the result register. While a result waits for out_ready, the
// input register still takes one more tick, then in_ready drops until the result is taken.
// Configuration registers are written through the cfg_ port and take effect on the next
// tick processed; write them only while no tick is in flight.
module door_auto_close_controller
  import dacc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  `include "door_auto_close_controller_assert.svh"

  // Configuration registers
  logic [15:0] delay_no_entry_r;
  logic [15:0] delay_after_entry_r;
  logic [15:0] settle_r;
  logic [15:0] confirm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_no_entry_r    <= CLOSE_DELAY_NO_ENTRY_RST;
      delay_after_entry_r <= CLOSE_DELAY_AFTER_ENTRY_RST;
      settle_r            <= CLOSE_SETTLE_RST;
      confirm_r           <= EXIT_CONFIRM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLOSE_DELAY_NO_ENTRY:    delay_no_entry_r    <= cfg_wdata;
        CFG_CLOSE_DELAY_AFTER_ENTRY: delay_after_entry_r <= cfg_wdata;
        CFG_CLOSE_SETTLE:            settle_r            <= cfg_wdata;
        CFG_EXIT_CONFIRM:            confirm_r           <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control: input register feeds result register
  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      adv;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Controller state
  logic [1:0]  prev_door_r,    prev_door_nxt;
  logic [1:0]  side_r,         side_nxt;
  logic        present_r,      present_nxt;
  logic        exit_win_r,     exit_win_nxt;
  logic [31:0] empty_stamp_r,  empty_stamp_nxt;
  logic        empty_valid_r,  empty_valid_nxt;
  logic [31:0] closed_stamp_r, closed_stamp_nxt;
  logic        closed_valid_r, closed_valid_nxt;
  logic [31:0] timer_start_r,  timer_start_nxt;
  logic        timer_run_r,    timer_run_nxt;
  logic [1:0]  tmr_mode_r,     tmr_mode_nxt;
  logic        arrived_r,      arrived_nxt;
  out_item_t   res_nxt;

  // Single-pass decision logic for the tick in the input register
  always_comb begin
    logic [1:0]  pos;
    logic [1:0]  door;
    logic        manual;
    logic [31:0] now;
    logic        occupied;
    logic [31:0] diff;
    logic [1:0]  mode;
    logic [15:0] delay;

    pos      = s1_data_r.car_position;
    door     = s1_data_r.door_state;
    manual   = s1_data_r.last_move_manual;
    now      = s1_data_r.now_ms;
    occupied = (pos == POS_INSIDE) || (pos == POS_BOTH);

    prev_door_nxt    = prev_door_r;
    side_nxt         = side_r;
    present_nxt      = present_r;
    exit_win_nxt     = exit_win_r;
    empty_stamp_nxt  = empty_stamp_r;
    empty_valid_nxt  = empty_valid_r;
    closed_stamp_nxt = closed_stamp_r;
    closed_valid_nxt = closed_valid_r;
    timer_start_nxt  = timer_start_r;
    timer_run_nxt    = timer_run_r;
    tmr_mode_nxt     = tmr_mode_r;
    arrived_nxt      = arrived_r;
    res_nxt          = '0;
    diff             = '0;

    // Last side seen by a single sensor
    if (pos == POS_OUTSIDE || pos == POS_INSIDE) begin
      side_nxt = pos;
    end

    // Door transition classification
    if (door != prev_door_r) begin
      unique case (door)
        DOOR_OPENING: begin
          if (manual)                      res_nxt.transition_event = EV_MANUAL_OPENING;
          else if (side_nxt == POS_OUTSIDE) res_nxt.transition_event = EV_ENTRY;
          else if (side_nxt == POS_INSIDE)  res_nxt.transition_event = EV_EXIT;
          else                             res_nxt.transition_event = EV_UNKNOWN_OPEN;
        end
        DOOR_CLOSING: begin
          res_nxt.transition_event = manual ? EV_MANUAL_CLOSING : EV_CLOSING;
        end
        DOOR_OPEN:    res_nxt.transition_event = EV_OPENED;
        default:      res_nxt.transition_event = EV_CLOSED;
      endcase
      prev_door_nxt = door;
    end

    // Closed-door settle and parked check
    if (door == DOOR_CLOSED) begin
      if (prev_door_r != DOOR_CLOSED) begin
        closed_stamp_nxt = now;
        closed_valid_nxt = 1'b1;
      end
      exit_win_nxt    = 1'b0;
      empty_valid_nxt = 1'b0;
      empty_stamp_nxt = '0;
      diff = now - closed_stamp_nxt;
      if (closed_valid_nxt && diff >= {16'd0, settle_r} && occupied && !present_r) begin
        present_nxt          = 1'b1;
        res_nxt.parked_event = 1'b1;
      end
    end else begin
      closed_valid_nxt = 1'b0;
      closed_stamp_nxt = '0;
    end

    // Manual open with a car present opens the exit window
    if (door == DOOR_OPEN && prev_door_r != DOOR_OPEN && manual && present_nxt) begin
      exit_win_nxt    = 1'b1;
      empty_valid_nxt = 1'b0;
      empty_stamp_nxt = '0;
    end

    // Departure confirmation
    if (exit_win_nxt) begin
      if (!occupied) begin
        if (!empty_valid_nxt) begin
          empty_stamp_nxt = now;
          empty_valid_nxt = 1'b1;
        end
        if ((now - empty_stamp_nxt) >= {16'd0, confirm_r}) begin
          present_nxt        = 1'b0;
          exit_win_nxt       = 1'b0;
          empty_valid_nxt    = 1'b0;
          empty_stamp_nxt    = '0;
          res_nxt.left_event = 1'b1;
        end
      end else begin
        empty_valid_nxt = 1'b0;
        empty_stamp_nxt = '0;
      end
    end

    // Auto-close timers
    mode  = (pos == POS_INSIDE) ? MODE_AFTER_ENTRY : MODE_NO_ENTRY;
    delay = (pos == POS_INSIDE) ? delay_after_entry_r : delay_no_entry_r;
    res_nxt.door_command = MOTOR_IDLE;
    if (pos == POS_OUTSIDE) begin
      res_nxt.door_command = MOTOR_OPEN;
      timer_run_nxt  = 1'b0;
      tmr_mode_nxt   = MODE_NONE;
      arrived_nxt    = 1'b1;
    end else if (pos != POS_BOTH && arrived_r) begin
      if (!timer_run_r || tmr_mode_r != mode) begin
        timer_start_nxt = now;
        timer_run_nxt   = 1'b1;
        tmr_mode_nxt    = mode;
      end else if ((now - timer_start_r) > {16'd0, delay}) begin
        arrived_nxt          = 1'b0;
        timer_run_nxt        = 1'b0;
        tmr_mode_nxt         = MODE_NONE;
        res_nxt.door_command = MOTOR_CLOSE;
      end
    end

    res_nxt.car_parked = present_nxt;
  end

  // State and result registers advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      prev_door_r    <= DOOR_CLOSED;
      side_r         <= POS_NONE;
      present_r      <= 1'b0;
      exit_win_r     <= 1'b0;
      empty_stamp_r  <= '0;
      empty_valid_r  <= 1'b0;
      closed_stamp_r <= '0;
      closed_valid_r <= 1'b0;
      timer_start_r  <= '0;
      timer_run_r    <= 1'b0;
      tmr_mode_r     <= MODE_NONE;
      arrived_r      <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        prev_door_r    <= prev_door_nxt;
        side_r         <= side_nxt;
        present_r      <= present_nxt;
        exit_win_r     <= exit_win_nxt;
        empty_stamp_r  <= empty_stamp_nxt;
        empty_valid_r  <= empty_valid_nxt;
        closed_stamp_r <= closed_stamp_nxt;
        closed_valid_r <= closed_valid_nxt;
        timer_start_r  <= timer_start_nxt;
        timer_run_r    <= timer_run_nxt;
        tmr_mode_r     <= tmr_mode_nxt;
        arrived_r      <= arrived_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_data_r <= res_nxt;
    end
  end

  // Checks on controller invariants
  `DACC_ASSERT_NOW(a_exit_needs_car, exit_win_r, present_r, "exit window open without a car")
  `DACC_ASSERT_NOW(a_timer_needs_arrival, timer_run_r, arrived_r, "close timer without arrival")
  `DACC_ASSERT_NOW(a_parked_sets_present, out_valid_r && out_data_r.parked_event, out_data_r.car_parked, "parked event without car present")
  `DACC_ASSERT_NOW(a_events_exclusive, out_valid_r, !(out_data_r.parked_event && out_data_r.left_event), "parked and left in one result")
  `DACC_ASSERT_NEXT(a_stage_moves, s1_valid_r && adv, out_valid_r, "ticked transaction lost")

endmodule

`default_nettype wire
